// ===== sv/rms_pkg.sv =====
// ----------------------------------------------------------------------------
// rms_pkg
// Shared types and constants for the running mean and deviation block.
// ----------------------------------------------------------------------------
package rms_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int CNT_W  = 17;
    localparam int SUM_W  = 32;
    localparam int SQ_W   = 47;
    localparam int NUM_W  = 128;
    localparam int Q_W    = 64;

    localparam logic [1:0] ADDR_MODE = 2'd0;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FEW      = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic start;
        logic ld_mul;
        logic ld_num;
        logic div_step;
        logic sqrt_step;
        logic mean_step;
        logic finish;
    } rms_cmd_t;

    typedef struct packed {
        logic last_step;
    } rms_stat_t;

endpackage

// ===== sv/rms_datapath.sv =====
// ----------------------------------------------------------------------------
// rms_datapath
// Snapshot of the totals, wide numerator, bit-serial divides and root.
// ----------------------------------------------------------------------------
module rms_datapath (
    input  logic                        aclk,
    input  rms_pkg::rms_cmd_t           cmd,
    output rms_pkg::rms_stat_t          stat,
    input  logic [rms_pkg::CNT_W-1:0]   snap_count,
    input  logic signed [rms_pkg::SUM_W-1:0] snap_sum,
    input  logic [rms_pkg::SQ_W-1:0]    snap_sq,
    input  logic                        snap_ovf,
    input  logic                        mode,
    input  logic [5:0]                  frac_bits,
    output logic [31:0]                 mean_value,
    output logic [31:0]                 std_dev,
    output logic [rms_pkg::CNT_W-1:0]   sample_total,
    output logic [1:0]                  status
);
    import rms_pkg::*;

    logic [CNT_W-1:0]  n_reg;
    logic              neg_reg, ovf_reg, mode_reg;
    logic [SUM_W-1:0]  mag_reg;
    logic [63:0]       sq_reg;
    logic [NUM_W-1:0]  pa_reg, pb_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  dq_reg;
    logic [64:0]       drem_reg;
    logic [33:0]       den_reg;
    logic [6:0]        step_reg;
    logic [63:0]       root_reg;
    logic [64:0]       srem_reg;
    logic [NUM_W-1:0]  mq_reg;
    logic [CNT_W:0]    mrem_reg;
    logic [NUM_W-1:0]  mnum_reg;

    logic [64:0]       drem_sh;
    logic [66:0]       srem_sh;
    logic [66:0]       strial;
    logic [CNT_W:0]    mrem_sh;
    logic [63:0]       qsat;

    assign drem_sh = {drem_reg[63:0], num_reg[NUM_W-1]};
    assign srem_sh = {srem_reg, dq_reg[NUM_W-1:NUM_W-2]};
    assign strial  = {1'b0, root_reg, 2'b01};
    assign mrem_sh = {mrem_reg[CNT_W-1:0], mnum_reg[NUM_W-1]};
    assign stat.last_step = (step_reg == 7'd0);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            n_reg    <= snap_count;
            neg_reg  <= snap_sum[SUM_W-1];
            mag_reg  <= snap_sum[SUM_W-1] ? SUM_W'(-snap_sum) : SUM_W'(snap_sum);
            sq_reg   <= 64'(snap_sq);
            ovf_reg  <= snap_ovf;
            mode_reg <= mode;
            step_reg <= 7'd127;
        end
        if (cmd.ld_mul) begin
            pa_reg   <= NUM_W'({47'd0, n_reg} * sq_reg);
            pb_reg   <= NUM_W'({32'd0, mag_reg} * {32'd0, mag_reg});
            den_reg  <= 34'({17'd0, n_reg} * {17'd0, n_reg - CNT_W'(mode_reg)});
            mnum_reg <= NUM_W'({mag_reg, 64'd0}) << frac_bits;
            mrem_reg <= '0;
            mq_reg   <= '0;
        end
        if (cmd.ld_num) begin
            num_reg  <= (pa_reg - pb_reg) << (7'(frac_bits) << 1);
            drem_reg <= '0;
            dq_reg   <= '0;
            step_reg <= 7'd127;
        end
        if (cmd.div_step) begin
            num_reg <= num_reg << 1;
            if (drem_sh >= 65'(den_reg)) begin
                drem_reg <= drem_sh - 65'(den_reg);
                dq_reg   <= {dq_reg[NUM_W-2:0], 1'b1};
            end else begin
                drem_reg <= drem_sh;
                dq_reg   <= {dq_reg[NUM_W-2:0], 1'b0};
            end
            step_reg <= (step_reg == 7'd0) ? 7'd63 : step_reg - 7'd1;
            if (step_reg == 7'd0) begin
                root_reg <= '0;
                srem_reg <= '0;
            end
        end
        if (cmd.mean_step) begin
            mnum_reg <= mnum_reg << 1;
            if (n_reg != '0 && mrem_sh >= {1'b0, n_reg}) begin
                mrem_reg <= mrem_sh - {1'b0, n_reg};
                mq_reg   <= {mq_reg[NUM_W-2:0], 1'b1};
            end else begin
                mrem_reg <= mrem_sh;
                mq_reg   <= {mq_reg[NUM_W-2:0], 1'b0};
            end
        end
        if (cmd.sqrt_step) begin
            dq_reg <= dq_reg << 2;
            if (srem_sh >= strial) begin
                srem_reg <= 65'(srem_sh - strial);
                root_reg <= {root_reg[62:0], 1'b1};
            end else begin
                srem_reg <= srem_sh[64:0];
                root_reg <= {root_reg[62:0], 1'b0};
            end
            step_reg <= step_reg - 7'd1;
        end
    end

    // mean quotient sits in bits 127..64 of the 128-bit quotient
    assign qsat = mq_reg[NUM_W-1:64];

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            if (neg_reg)
                mean_value <= (qsat > 64'h8000_0000) ? 32'h8000_0000 : 32'(-qsat[31:0]);
            else
                mean_value <= (qsat > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qsat[31:0];
            if (n_reg < CNT_W'(2))
                std_dev <= '0;
            else
                std_dev <= (root_reg > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root_reg[31:0];
            sample_total <= n_reg;
            status <= ovf_reg ? STATUS_OVERFLOW :
                      (n_reg < CNT_W'(2) ? STATUS_FEW : STATUS_OK);
        end
    end
endmodule

// ===== sv/rms_ctrl.sv =====
// ----------------------------------------------------------------------------
// rms_ctrl
// Sequencer for the closing divide and square root.
// ----------------------------------------------------------------------------
module rms_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                go,
    output logic                busy,
    output logic                done,
    input  rms_pkg::rms_stat_t  stat,
    output rms_pkg::rms_cmd_t   cmd
);
    import rms_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_NUM  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        done = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (go) begin
                    cmd.start = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.ld_mul = 1'b1;
                state_next = S_NUM;
            end
            S_NUM: begin
                cmd.ld_num = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cmd.mean_step = 1'b1;
                if (stat.last_step) state_next = S_SQRT;
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (stat.last_step) state_next = S_FIN;
            end
            S_FIN: begin
                cmd.finish = 1'b1;
                done = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

// ===== sv/running_mean_stddev.sv =====
// ----------------------------------------------------------------------------
// running_mean_stddev
// Mean and standard deviation of signed sample datasets.
// ----------------------------------------------------------------------------
// Samples enter on s_axis (tdata = sample, tlast = end of dataset), one per
// cycle, except that a tlast sample stalls while the back end is busy or a
// result is still held. Count, sum and sum of squares grow with each accepted
// sample up to MAX_COUNT samples, after which the overflow flag is set. The
// tlast sample hands the totals to the back end and clears the accumulator.
// The back end runs a 128-step restoring divide (mean in parallel) and a
// 64-step bit-serial square root before the result goes to m_axis. While the
// back end is busy, samples keep entering until a second dataset closes; that
// tlast waits until the back end is free and the result is taken.
// Results sit in an output register on m_axis until taken; a stalled
// receiver holds the result, and the next tlast then stalls.
// Reset (aresetn low, synchronous) clears the accumulator, the mode register,
// the output valid and the sequencer state.
// Register 0 at address 0: bit 0 selects population (0) or sample (1).
// ----------------------------------------------------------------------------
module running_mean_stddev #(
    parameter int MAX_COUNT   = 65536,
    parameter int FRAC_BITS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // [31:0] mean_value, [63:32] std_dev,
                                        // [80:64] sample_total, [82:81] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rms_pkg::*;

    logic [CNT_W-1:0]       cnt_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic                   ovf_reg;
    logic                   mode_reg;
    logic                   busy, done, go;
    logic                   out_valid_reg;
    rms_cmd_t               cmd;
    rms_stat_t              stat;
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [SUM_W-1:0] xe;
    logic [SQ_W-1:0]        xsq;
    logic                   accept;
    logic [31:0]            mean_value, std_dev;
    logic [CNT_W-1:0]       sample_total;
    logic [1:0]             status;

    assign pready = 1'b1;
    assign prdata = {31'd0, mode_reg};

    assign x   = s_axis_tdata[SAMPLE_BITS-1:0];
    assign xe  = SUM_W'(x);
    assign xsq = SQ_W'(xe * xe);

    // tlast needs a free back end and the previous result drained
    assign s_axis_tready = !(s_axis_tlast && (busy || out_valid_reg));
    assign accept = s_axis_tvalid && s_axis_tready;
    assign go = accept && s_axis_tlast;

    logic               take;
    logic [CNT_W-1:0]   cnt_n;
    logic signed [SUM_W-1:0] sum_n;
    logic [SQ_W-1:0]    sq_n;
    logic               ovf_n;

    assign take  = cnt_reg < CNT_W'(MAX_COUNT);
    assign cnt_n = take ? cnt_reg + 1'b1 : cnt_reg;
    assign sum_n = take ? sum_reg + xe : sum_reg;
    assign sq_n  = take ? sq_reg + xsq : sq_reg;
    assign ovf_n = ovf_reg | !take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            sum_reg <= '0;
            sq_reg  <= '0;
            ovf_reg <= 1'b0;
            mode_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == ADDR_MODE) mode_reg <= pwdata[0];
            if (accept) begin
                if (s_axis_tlast) begin
                    cnt_reg <= '0;
                    sum_reg <= '0;
                    sq_reg  <= '0;
                    ovf_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_n;
                    sum_reg <= sum_n;
                    sq_reg  <= sq_n;
                    ovf_reg <= ovf_n;
                end
            end
            if (done) out_valid_reg <= 1'b1;
            else if (m_axis_tready) out_valid_reg <= 1'b0;
        end
    end

    rms_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .go(go), .busy(busy), .done(done),
        .stat(stat), .cmd(cmd)
    );

    rms_datapath u_dp (
        .aclk(aclk), .cmd(cmd), .stat(stat),
        .snap_count(cnt_n), .snap_sum(sum_n), .snap_sq(sq_n), .snap_ovf(ovf_n),
        .mode(mode_reg), .frac_bits(6'(FRAC_BITS)),
        .mean_value(mean_value), .std_dev(std_dev),
        .sample_total(sample_total), .status(status)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, status, sample_total, std_dev, mean_value};
endmodule

// ===== sv/rms_checker.sv =====
// ----------------------------------------------------------------------------
// rms_checker
// Port-level checks for running_mean_stddev.
// ----------------------------------------------------------------------------
module rms_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic        pready
);
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[82:81] == 2'd1 |-> m_axis_tdata[63:32] == 32'd0)
        else $error("deviation nonzero with too few samples");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[82:81] != 2'd3)
        else $error("bad status");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !m_axis_tvalid)
        else $error("result before computation");
    assert property (@(posedge aclk) pready)
        else $error("pready low");
endmodule

bind running_mean_stddev rms_checker u_rms_checker (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .pready(pready)
);

// ===== tb/running_mean_stddev_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_mean_stddev_tb
// Streams signed sample datasets into the block under random valid/ready gaps
// (one phase without), predicts mean, deviation, count and status per dataset,
// and compares each result field by field. Mode register toggled between phases.
// ----------------------------------------------------------------------------
module running_mean_stddev_tb;
    import rms_pkg::*;

    localparam int MAX_CNT   = 65536;
    localparam int LIMIT_CYC = 1500000;

    typedef struct packed {
        logic [31:0] mean_value;
        logic [31:0] std_dev;
        logic [16:0] sample_total;
        logic [1:0]  status;
    } stats_t;

    typedef struct {
        logic [15:0] sample;
        logic        last;
        bit          typed;
        stats_t      want;
    } row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [87:0] m_axis_tdata;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [1:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    running_mean_stddev uut (.*);

    always #10 aclk = ~aclk;

    // predictor state
    int unsigned      acc_count;
    logic signed [63:0] acc_sum;
    logic [63:0]      acc_sq;
    bit               acc_over;
    bit               mode;

    stats_t      stats_q[$];
    bit          typed_q[$];
    int          errors = 0, mism = 0, results = 0, sent = 0, datasets = 0;
    int          cycles = 0;
    bit          no_idle = 0;
    row_t        rows[$];

    function automatic stats_t close_dataset();
        stats_t r;
        logic [63:0]  n, mag, q;
        logic [127:0] num, quot, root, cand;
        bit neg;
        n = acc_count;
        neg = acc_sum < 0;
        mag = neg ? -acc_sum : acc_sum;
        q = n ? (mag << 16) / n : 0;
        if (neg) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            r.mean_value = -q[31:0];
        end else begin
            if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
            r.mean_value = q[31:0];
        end
        if (n < 2) begin
            r.std_dev = 0;
        end else begin
            num = (128'(n) * 128'(acc_sq) - 128'(mag) * 128'(mag)) << 32;
            quot = num / 128'(n * (n - mode));
            root = 0;
            for (int b = 63; b >= 0; b--) begin
                cand = root | (128'd1 << b);
                if (cand * cand <= quot) root = cand;
            end
            r.std_dev = (root > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
        end
        r.sample_total = n[16:0];
        r.status = acc_over ? STATUS_OVERFLOW : (n < 2 ? STATUS_FEW : STATUS_OK);
        acc_count = 0; acc_sum = 0; acc_sq = 0; acc_over = 0;
        return r;
    endfunction

    task automatic predict_sample(input logic [15:0] s, input logic l,
                                  input bit typed, input stats_t want);
        logic signed [63:0] x;
        stats_t r;
        x = $signed(s);
        if (acc_count < MAX_CNT) begin
            acc_count++; acc_sum += x; acc_sq += x * x;
        end else begin
            acc_over = 1;
        end
        if (l) begin
            r = close_dataset();
            if (typed && r != want) begin
                errors++;
                if (mism++ < 10)
                    $display("table row disagrees with predictor at dataset %0d", datasets);
            end
            stats_q.push_back(r);
            datasets++;
        end
    endtask

    task automatic send(input logic [15:0] s, input logic l);
        while (!no_idle && $urandom_range(99) < 33) begin
            s_axis_tvalid <= 0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1; s_axis_tdata <= s; s_axis_tlast <= l;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sent++;
        @(negedge aclk);
    endtask

    task automatic set_mode(input bit m);
        s_axis_tvalid <= 0;
        while (stats_q.size() != 0) @(negedge aclk);
        repeat (250) @(negedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 0; pwdata <= {31'd0, m};
        @(negedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        mode = m;
    endtask

    task automatic random_dataset(input int len, input int kind);
        logic [15:0] s;
        for (int i = 0; i < len; i++) begin
            case (kind)
                0: s = $urandom;
                1: s = $urandom_range(2) == 0 ? 16'h8000 : 16'h7FFF;
                default: s = 16'($signed($urandom_range(40)) - 20);
            endcase
            predict_sample(s, i == len - 1, 0, '{default: 0});
            send(s, i == len - 1);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        stats_t got, exp_r;
        if (aresetn) begin
            cycles++;
            if (m_axis_tvalid && m_axis_tready) begin
                got.mean_value   = m_axis_tdata[31:0];
                got.std_dev      = m_axis_tdata[63:32];
                got.sample_total = m_axis_tdata[80:64];
                got.status       = m_axis_tdata[82:81];
                results++;
                if (stats_q.size() == 0) begin
                    errors++;
                    if (mism++ < 10) $display("unexpected result %h", m_axis_tdata);
                end else begin
                    exp_r = stats_q.pop_front();
                    if (got != exp_r) begin
                        errors++;
                        if (mism++ < 10)
                            $display("mismatch: exp mean %h sd %h n %0d st %0d, got mean %h sd %h n %0d st %0d",
                                exp_r.mean_value, exp_r.std_dev, exp_r.sample_total,
                                exp_r.status, got.mean_value, got.std_dev,
                                got.sample_total, got.status);
                    end
                end
            end
            if (cycles > LIMIT_CYC) begin
                $display("running_mean_stddev verification failed");
                $finish;
            end
        end
    end

    always @(negedge aclk)
        m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 33);

    function automatic row_t mk(logic [15:0] s, logic l, bit t,
                                logic [31:0] mv, logic [31:0] sd,
                                logic [16:0] n, logic [1:0] st);
        row_t r;
        r.sample = s; r.last = l; r.typed = t;
        r.want = '{mv, sd, n, st};
        return r;
    endfunction

    initial begin
        acc_count = 0; acc_sum = 0; acc_sq = 0; acc_over = 0; mode = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        // single samples: few-sample status
        rows.push_back(mk(16'h7FFF, 1, 1, 32'h7FFF_0000, 0, 1, STATUS_FEW));
        rows.push_back(mk(16'h8000, 1, 1, 32'h8000_0000, 0, 1, STATUS_FEW));
        rows.push_back(mk(16'h0000, 1, 1, 0, 0, 1, STATUS_FEW));
        rows.push_back(mk(16'hFFFF, 1, 1, 32'hFFFF_0000, 0, 1, STATUS_FEW));
        // two equal extremes: zero deviation
        rows.push_back(mk(16'h8000, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(16'h8000, 1, 1, 32'h8000_0000, 0, 2, STATUS_OK));
        // opposite extremes
        rows.push_back(mk(16'h7FFF, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(16'h8000, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(16'h7FFF, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(16'h8000, 1, 0, 0, 0, 0, 0));
        rows.push_back(mk(16'h0001, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(16'h0002, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(16'hFFFD, 1, 0, 0, 0, 0, 0));
        foreach (rows[i]) begin
            predict_sample(rows[i].sample, rows[i].last, rows[i].typed, rows[i].want);
            send(rows[i].sample, rows[i].last);
        end
        set_mode(1);
        random_dataset(2, 1);
        random_dataset(5, 0);
        for (int ph = 0; ph < 4; ph++) begin
            no_idle = (ph == 2);
            for (int d = 0; d < 55; d++)
                random_dataset($urandom_range(12, 1), $urandom_range(5) == 0 ? 1 :
                               ($urandom_range(3) == 0 ? 2 : 0));
            set_mode(ph[0]);
        end
        no_idle = 0;
        random_dataset(3, 0);
        s_axis_tvalid <= 0;
        while (stats_q.size() != 0) @(negedge aclk);
        repeat (250) @(negedge aclk);
        $display("sent %0d samples in %0d datasets, %0d results checked, both modes",
                 sent, datasets, results);
        if (errors == 0)
            $display("running_mean_stddev verification clean");
        else
            $display("running_mean_stddev verification failed");
        $finish;
    end
endmodule
